>>> src/iol_pkg.sv
// Shared types and constants for the indexed ordered list.
`timescale 1ns / 1ps

package iol_pkg;

   localparam int CAPACITY_DEFAULT = 16;
   localparam int VALUE_W          = 32;
   localparam int INDEX_W          = 4;
   localparam int COUNT_OUT_W      = 5;
   localparam int READ_SLOTS       = 1 << INDEX_W;

   typedef enum logic [1:0] {
      CMD_APPEND = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_READ   = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   // Broadcast from the control to every cell in the row.
   typedef struct packed {
      logic append;
      logic remove;
   } cell_ctl_type;

endpackage

>>> src/iol_cell.sv
// One storage cell of the list: loads a new tail value or takes its neighbor's entry.
`timescale 1ns / 1ps

module iol_cell #(
   parameter int POS   = 0,
   parameter int CMP_W = 5
) (
   input  logic                                clock,
   input  iol_pkg::cell_ctl_type               ctl,
   input  logic [CMP_W-1:0]                    count,
   input  logic [CMP_W-1:0]                    idx,
   input  logic signed [iol_pkg::VALUE_W-1:0]  new_value,
   input  logic signed [iol_pkg::VALUE_W-1:0]  next_value,
   output logic signed [iol_pkg::VALUE_W-1:0]  value
);

   localparam logic [CMP_W-1:0] POS_C = CMP_W'(POS);

   logic signed [iol_pkg::VALUE_W-1:0] value_ff;
   logic signed [iol_pkg::VALUE_W-1:0] value_in;

   // Cells at or past the deleted slot close up by one; a cell past the
   // last entry may pick up junk, which is never read before it is written.
   always_comb begin
      value_in = value_ff;
      priority if (ctl.append && (POS_C == count)) begin
         value_in = new_value;
      end else if (ctl.remove && (POS_C >= idx)) begin
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

>>> src/indexed_ordered_list.sv
// Top level of the indexed ordered list: control, cell row and result register.
`timescale 1ns / 1ps

// Bounded ordered list of signed 32-bit values held in a row of CAPACITY
// cells. A transaction appends at the tail, deletes at an index (later
// entries close up) or reads at an index. All cells shift or load in
// parallel at the accepting edge, so busy stays low and a new transaction
// may start in every cycle. The result appears on the rsp_ ports for one
// cycle, marked by rsp_valid, in the cycle after the transaction is
// accepted; it must be captured then. Appending to a full list, or an index
// at or beyond the count, leaves the list unchanged and is flagged in
// rsp_status. rsp_entry_count carries the low five bits of the count. The
// list is empty after reset.
module indexed_ordered_list #(
   parameter int CAPACITY = iol_pkg::CAPACITY_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [1:0]                             req_cmd,
   input  logic signed [iol_pkg::VALUE_W-1:0]     req_value,
   input  logic [iol_pkg::INDEX_W-1:0]            req_index,
   output logic                                   rsp_valid,
   output logic signed [iol_pkg::VALUE_W-1:0]     rsp_read_value,
   output logic [1:0]                             rsp_status,
   output logic [iol_pkg::COUNT_OUT_W-1:0]        rsp_entry_count
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > iol_pkg::INDEX_W) ? CNT_W : iol_pkg::INDEX_W;
   localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

   logic [CNT_W-1:0]                        count_ff;
   logic [CNT_W-1:0]                        count_in;
   logic                                    rsp_valid_ff;
   logic signed [iol_pkg::VALUE_W-1:0]      rsp_read_value_ff;
   logic signed [iol_pkg::VALUE_W-1:0]      rsp_read_value_in;
   iol_pkg::status_type                     rsp_status_ff;
   iol_pkg::status_type                     rsp_status_in;
   logic [iol_pkg::COUNT_OUT_W-1:0]         rsp_entry_count_ff;

   logic                                    accept;
   logic [CMP_W-1:0]                        count_cmp;
   logic [CMP_W-1:0]                        idx_cmp;
   logic                                    in_range;
   iol_pkg::cell_ctl_type                   ctl;

   logic signed [iol_pkg::VALUE_W-1:0]      cell_value [CAPACITY];
   logic signed [iol_pkg::VALUE_W-1:0]      read_win [iol_pkg::READ_SLOTS];

   assign busy      = 1'b0;
   assign accept    = start && !busy;
   assign count_cmp = CMP_W'(count_ff);
   assign idx_cmp   = CMP_W'(req_index);
   assign in_range  = idx_cmp < count_cmp;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [iol_pkg::VALUE_W-1:0] next_value;
      if (i == CAPACITY - 1) begin : g_last
         assign next_value = '0;
      end else begin : g_mid
         assign next_value = cell_value[i+1];
      end
      iol_cell #(
         .POS   (i),
         .CMP_W (CMP_W)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .count      (count_cmp),
         .idx        (idx_cmp),
         .new_value  (req_value),
         .next_value (next_value),
         .value      (cell_value[i])
      );
   end

   // Read window over the cells an index can reach.
   for (genvar k = 0; k < iol_pkg::READ_SLOTS; k++) begin : g_win
      if (k < CAPACITY) begin : g_hit
         assign read_win[k] = cell_value[k];
      end else begin : g_miss
         assign read_win[k] = '0;
      end
   end

   always_comb begin
      ctl               = '0;
      count_in          = count_ff;
      rsp_read_value_in = '0;
      rsp_status_in     = iol_pkg::ST_DONE;
      if (accept) begin
         unique case (req_cmd)
            iol_pkg::CMD_APPEND: begin
               if (count_cmp < CAP_C) begin
                  ctl.append = 1'b1;
                  count_in   = count_ff + CNT_W'(1);
               end else begin
                  rsp_status_in = iol_pkg::ST_FULL;
               end
            end
            iol_pkg::CMD_DELETE: begin
               if (in_range) begin
                  ctl.remove = 1'b1;
                  count_in   = count_ff - CNT_W'(1);
               end else begin
                  rsp_status_in = iol_pkg::ST_RANGE;
               end
            end
            iol_pkg::CMD_READ: begin
               if (in_range) begin
                  rsp_read_value_in = read_win[req_index];
               end else begin
                  rsp_status_in = iol_pkg::ST_RANGE;
               end
            end
            default: begin
               // Unused code: drop it, report done.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      rsp_read_value_ff  <= rsp_read_value_in;
      rsp_status_ff      <= rsp_status_in;
      rsp_entry_count_ff <= iol_pkg::COUNT_OUT_W'(count_in);
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_entry_count_ff;

endmodule

>>> src/iol_checker.sv
// Port-level assertions for the indexed ordered list, bound to the top level.
`timescale 1ns / 1ps

module iol_checker #(
   parameter int CAPACITY = iol_pkg::CAPACITY_DEFAULT
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  start,
   input logic                                  busy,
   input logic [1:0]                            req_cmd,
   input logic signed [iol_pkg::VALUE_W-1:0]    req_value,
   input logic [iol_pkg::INDEX_W-1:0]           req_index,
   input logic                                  rsp_valid,
   input logic signed [iol_pkg::VALUE_W-1:0]    rsp_read_value,
   input logic [1:0]                            rsp_status,
   input logic [iol_pkg::COUNT_OUT_W-1:0]       rsp_entry_count
);

   localparam logic [iol_pkg::COUNT_OUT_W-1:0] CAP_OUT = iol_pkg::COUNT_OUT_W'(CAPACITY);

   // Every accepted transaction gives exactly one result, in the next cycle.
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_valid)
      else $error("accepted transaction gave no result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_valid)
      else $error("result without a transaction");

   // A full report only happens with the list at capacity.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == iol_pkg::ST_FULL) |-> rsp_entry_count == CAP_OUT)
      else $error("full status with list not at capacity");

   // Failed or non-read transactions carry a zero value.
   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != iol_pkg::ST_DONE ||
                     $past(req_cmd) != iol_pkg::CMD_READ)) |-> rsp_read_value == '0)
      else $error("nonzero value on a result that is not a read");

endmodule

bind indexed_ordered_list iol_checker #(.CAPACITY(CAPACITY)) u_iol_checker (.*);

>>> sim/iol_checker.sv
// Checker for the indexed ordered list: predicts each result and compares it with the output.
`timescale 1ns / 1ps

module iol_tb_checker (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        start,
   input  logic                                        busy,
   input  logic [1:0]                                  req_cmd,
   input  logic signed [iol_pkg::VALUE_W-1:0]          req_value,
   input  logic [iol_pkg::INDEX_W-1:0]                 req_index,
   input  logic                                        rsp_valid,
   input  logic signed [iol_pkg::VALUE_W-1:0]          rsp_read_value,
   input  logic [1:0]                                  rsp_status,
   input  logic [iol_pkg::COUNT_OUT_W-1:0]             rsp_entry_count,
   output int                                          fail_count,
   output int                                          outstanding,
   output int                                          checked_count,
   output int                                          full_hits,
   output int                                          range_hits
);

   typedef struct packed {
      logic signed [iol_pkg::VALUE_W-1:0] read_value;
      iol_pkg::status_type                status;
      logic [iol_pkg::COUNT_OUT_W-1:0]    entry_count;
   } list_result_type;

   list_result_type                    pending_results[$];
   logic signed [iol_pkg::VALUE_W-1:0] list_cells[iol_pkg::CAPACITY_DEFAULT];
   int unsigned                        list_len;

   // Apply one transaction to the list copy and return the result it should produce.
   function automatic list_result_type apply_list_command(
         input logic [1:0]                       cmd,
         input logic signed [iol_pkg::VALUE_W-1:0] value,
         input logic [iol_pkg::INDEX_W-1:0]      index);
      list_result_type r;
      int unsigned     i;
      r.read_value = '0;
      r.status     = iol_pkg::ST_DONE;
      unique case (cmd)
         iol_pkg::CMD_APPEND: begin
            if (list_len >= iol_pkg::CAPACITY_DEFAULT) begin
               r.status = iol_pkg::ST_FULL;
            end else begin
               list_cells[list_len] = value;
               list_len++;
            end
         end
         iol_pkg::CMD_DELETE: begin
            if (index >= list_len) begin
               r.status = iol_pkg::ST_RANGE;
            end else begin
               // close up the entries behind the removed one
               for (i = index; i + 1 < list_len; i++)
                  list_cells[i] = list_cells[i + 1];
               list_len--;
            end
         end
         iol_pkg::CMD_READ: begin
            if (index >= list_len)
               r.status = iol_pkg::ST_RANGE;
            else
               r.read_value = list_cells[index];
         end
         default: ;  // unused code: list untouched, plain done
      endcase
      r.entry_count = list_len[iol_pkg::COUNT_OUT_W-1:0];
      return r;
   endfunction

   task automatic note_mismatch(input string what, input longint want, input longint got);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t ns: %s expected %0d got %0d", $time, what, want, got);
   endtask

   always @(posedge clock) begin : watch
      list_result_type want;
      if (reset) begin
         list_len      = 0;
         fail_count    = 0;
         checked_count = 0;
         full_hits     = 0;
         range_hits    = 0;
         pending_results.delete();
      end else begin
         // compare before pushing so a result never meets its own transaction
         if (rsp_valid) begin
            if (pending_results.size() == 0) begin
               note_mismatch("unexpected result, entry_count", -1, rsp_entry_count);
            end else begin
               want = pending_results.pop_front();
               checked_count++;
               if (want.status == iol_pkg::ST_FULL)  full_hits++;
               if (want.status == iol_pkg::ST_RANGE) range_hits++;
               if (rsp_read_value !== want.read_value)
                  note_mismatch("read_value", want.read_value, rsp_read_value);
               if (rsp_status !== want.status)
                  note_mismatch("status", want.status, rsp_status);
               if (rsp_entry_count !== want.entry_count)
                  note_mismatch("entry_count", want.entry_count, rsp_entry_count);
            end
         end
         if (start && !busy)
            pending_results.push_back(apply_list_command(req_cmd, req_value, req_index));
      end
      outstanding = pending_results.size();
   end

endmodule

>>> sim/tb_top.sv
// Top of the indexed ordered list testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

   localparam logic [1:0] CMD_UNUSED   = 2'd3;
   localparam int         RANDOM_ITEMS = 1880;
   localparam int         QUIET_TAIL   = 200;

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                start;
   logic                                busy;
   logic [1:0]                          req_cmd;
   logic signed [iol_pkg::VALUE_W-1:0]  req_value;
   logic [iol_pkg::INDEX_W-1:0]         req_index;
   logic                                rsp_valid;
   logic signed [iol_pkg::VALUE_W-1:0]  rsp_read_value;
   logic [1:0]                          rsp_status;
   logic [iol_pkg::COUNT_OUT_W-1:0]     rsp_entry_count;

   int fail_count;
   int outstanding;
   int checked_count;
   int full_hits;
   int range_hits;
   int fill;
   int sent;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   indexed_ordered_list dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_value       (req_value),
      .req_index       (req_index),
      .rsp_valid       (rsp_valid),
      .rsp_read_value  (rsp_read_value),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

   iol_tb_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_value       (req_value),
      .req_index       (req_index),
      .rsp_valid       (rsp_valid),
      .rsp_read_value  (rsp_read_value),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .fail_count      (fail_count),
      .outstanding     (outstanding),
      .checked_count   (checked_count),
      .full_hits       (full_hits),
      .range_hits      (range_hits)
   );

   // Call at a falling edge; returns at the falling edge after the transaction is taken.
   task automatic issue(input logic [1:0] cmd, input logic [iol_pkg::VALUE_W-1:0] value,
                        input logic [iol_pkg::INDEX_W-1:0] index);
      start     <= 1'b1;
      req_cmd   <= cmd;
      req_value <= value;
      req_index <= index;
      do @(posedge clock); while (busy);
      @(negedge clock);
      sent++;
      // rough fill, only used to aim indexes
      if (cmd == iol_pkg::CMD_APPEND && fill < iol_pkg::CAPACITY_DEFAULT) fill++;
      if (cmd == iol_pkg::CMD_DELETE && index < fill) fill--;
   endtask

   task automatic pause(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
   endtask

   initial begin
      #3_000_000;
      $display("indexed_ordered_list: mismatch");
      $finish;
   end

   initial begin : stimulus
      int                           mode;
      int                           pick;
      logic [1:0]                   cmd;
      logic [iol_pkg::INDEX_W-1:0]  index;
      reset     = 1'b1;
      start     = 1'b0;
      req_cmd   = iol_pkg::CMD_APPEND;
      req_value = '0;
      req_index = '0;
      fill      = 0;
      sent      = 0;
      mode      = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty list: reads and deletes fall out of range, unused code is a no-op
      issue(iol_pkg::CMD_READ, 32'h0, 4'd0);
      issue(iol_pkg::CMD_DELETE, 32'h0, 4'd15);
      issue(CMD_UNUSED, 32'hFFFF_FFFF, 4'd15);
      // fill to capacity with the value extremes first
      issue(iol_pkg::CMD_APPEND, 32'h7FFF_FFFF, 4'd0);
      issue(iol_pkg::CMD_APPEND, 32'h8000_0000, 4'd0);
      issue(iol_pkg::CMD_APPEND, 32'h0000_0000, 4'd0);
      issue(iol_pkg::CMD_APPEND, 32'hFFFF_FFFF, 4'd0);
      for (int k = 4; k < iol_pkg::CAPACITY_DEFAULT; k++)
         issue(iol_pkg::CMD_APPEND, (k % 2) ? 32'h5555_5555 + k : 32'hAAAA_AAAA - k, 4'd0);
      issue(iol_pkg::CMD_APPEND, 32'h1234_5678, 4'd0);   // full
      issue(iol_pkg::CMD_READ, 32'h0, 4'd15);
      issue(iol_pkg::CMD_READ, 32'h0, 4'd0);
      issue(iol_pkg::CMD_DELETE, 32'h0, 4'd15);          // tail
      issue(iol_pkg::CMD_DELETE, 32'h0, 4'd0);           // head
      issue(iol_pkg::CMD_READ, 32'h0, 4'd14);            // just past the end
      issue(iol_pkg::CMD_DELETE, 32'h0, 4'd7);           // middle
      issue(CMD_UNUSED, 32'h0, 4'd0);
      drain();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // swing between growing, shrinking and mixed traffic
         if (n % 64 == 0) mode = $urandom_range(0, 2);
         pick = $urandom_range(0, 99);
         unique case (mode)
            0:       cmd = (pick < 65) ? iol_pkg::CMD_APPEND :
                           (pick < 75) ? iol_pkg::CMD_DELETE :
                           (pick < 95) ? iol_pkg::CMD_READ : CMD_UNUSED;
            1:       cmd = (pick < 15) ? iol_pkg::CMD_APPEND :
                           (pick < 70) ? iol_pkg::CMD_DELETE :
                           (pick < 95) ? iol_pkg::CMD_READ : CMD_UNUSED;
            default: cmd = (pick < 35) ? iol_pkg::CMD_APPEND :
                           (pick < 60) ? iol_pkg::CMD_DELETE :
                           (pick < 95) ? iol_pkg::CMD_READ : CMD_UNUSED;
         endcase
         if (fill > 0 && $urandom_range(0, 99) < 85)
            index = iol_pkg::INDEX_W'($urandom_range(0, fill - 1));
         else
            index = iol_pkg::INDEX_W'($urandom_range(0, 15));
         issue(cmd, $urandom, index);
         if (n == RANDOM_ITEMS / 2)
            drain();
         else if (n < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 5) == 0)
            pause($urandom_range(1, 8));
      end

      drain();
      repeat (5) @(negedge clock);
      $display("sent %0d transactions, %0d results checked", sent, checked_count);
      $display("full-list appends hit %0d times, out-of-range indexes %0d times",
               full_hits, range_hits);
      if (fail_count == 0)
         $display("indexed_ordered_list: match");
      else
         $display("indexed_ordered_list: mismatch");
      $finish;
   end

endmodule
